/* hw/rtl/hfb_pkg.sv */
// Shared types, register codes and the world transform for the heightfield bounds block.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package hfb_pkg;

    localparam int LOCAL_W = 17;
    localparam int COORD_W = 32;

    localparam logic [LOCAL_W-1:0] MINUS_HALF = 17'h1C000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_MATRIX_X = 3'd0;
    localparam logic [2:0] REG_MATRIX_Y = 3'd1;
    localparam logic [2:0] REG_MATRIX_Z = 3'd2;
    localparam logic [2:0] REG_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_ROWS     = 3'd4;
    localparam logic [2:0] REG_COL_STEP = 3'd5;
    localparam logic [2:0] REG_ROW_STEP = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [LOCAL_W-1:0] local_t;
    typedef logic signed [15:0]        height_t;

    typedef struct packed {
        logic [63:0] mrow_x;
        logic [63:0] mrow_y;
        logic [63:0] mrow_z;
        logic [10:0] columns;
        logic [10:0] rows;
        logic [15:0] col_step;
        logic [15:0] row_step;
    } cfg_t;

    typedef struct packed {
        coord_t max_z;
        coord_t max_y;
        coord_t max_x;
        coord_t min_z;
        coord_t min_y;
        coord_t min_x;
    } bounds_t;

    // One matrix row applied to (x, h, z, 1). Terms aligned to Q.23, summed exactly,
    // rounded half up to Q16.16 and saturated.
    function automatic coord_t world(input logic [63:0] row, input local_t x,
                                     input height_t h, input local_t z);
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [15:0] ct;
        logic signed [32:0] px;
        logic signed [32:0] pz;
        logic signed [31:0] py;
        logic [41:0]        sum;
        logic [41:0]        rnd;
        logic [34:0]        r;
        coord_t             res;
        cx  = row[15:0];
        cy  = row[31:16];
        cz  = row[47:32];
        ct  = row[63:48];
        px  = cx * x;
        pz  = cz * z;
        py  = cy * h;
        sum = {{9{px[32]}}, px} + {{9{pz[32]}}, pz}
            + {{3{py[31]}}, py, 7'd0} + {{11{ct[15]}}, ct, 15'd0};
        rnd = sum + 42'd64;
        r   = rnd[41:7];
        if (r[34:31] == 4'b0000 || r[34:31] == 4'b1111) begin
            res = r[31:0];
        end else if (r[34]) begin
            res = COORD_MIN;
        end else begin
            res = COORD_MAX;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/hfb_cfg.sv */
// APB register file of the heightfield bounds block: matrix rows, grid size, steps.
// Depends on hfb_pkg.
`timescale 1ns / 1ps

module hfb_cfg import hfb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[5:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mrow_x   <= 64'h100;
            cfg_reg.mrow_y   <= 64'h100_0000;
            cfg_reg.mrow_z   <= 64'h100_0000_0000;
            cfg_reg.columns  <= 11'd2;
            cfg_reg.rows     <= 11'd2;
            cfg_reg.col_step <= 16'd32768;
            cfg_reg.row_step <= 16'd32768;
        end else if (wr_en) begin
            unique case (index)
                REG_MATRIX_X: cfg_reg.mrow_x   <= pwdata;
                REG_MATRIX_Y: cfg_reg.mrow_y   <= pwdata;
                REG_MATRIX_Z: cfg_reg.mrow_z   <= pwdata;
                REG_COLUMNS:  cfg_reg.columns  <= pwdata[10:0];
                REG_ROWS:     cfg_reg.rows     <= pwdata[10:0];
                REG_COL_STEP: cfg_reg.col_step <= pwdata[15:0];
                REG_ROW_STEP: cfg_reg.row_step <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_MATRIX_X: prdata = cfg_reg.mrow_x;
            REG_MATRIX_Y: prdata = cfg_reg.mrow_y;
            REG_MATRIX_Z: prdata = cfg_reg.mrow_z;
            REG_COLUMNS:  prdata = {53'd0, cfg_reg.columns};
            REG_ROWS:     prdata = {53'd0, cfg_reg.rows};
            REG_COL_STEP: prdata = {48'd0, cfg_reg.col_step};
            REG_ROW_STEP: prdata = {48'd0, cfg_reg.row_step};
            default:      prdata = 64'd0;
        endcase
    end

endmodule

/* hw/rtl/hfb_walk.sv */
// Grid walker: column/row counters and Q1.15 local position accumulators.
// Depends on hfb_pkg; advances once per accepted word.
`timescale 1ns / 1ps

module hfb_walk import hfb_pkg::*; #(
    parameter int MAX_GRID_SIZE = 1024
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   step,
    output local_t local_x,
    output local_t local_z,
    output logic   grid_last
);

    localparam int CNT_W = (MAX_GRID_SIZE > 2) ? $clog2(MAX_GRID_SIZE) : 1;
    localparam int CMP_W = (CNT_W + 1 > 12) ? CNT_W + 1 : 12;
    localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'(MAX_GRID_SIZE);
    localparam logic [CMP_W-1:0] SIZE_MIN = CMP_W'(2);

    logic [CNT_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [LOCAL_W-1:0] lx_reg, lx_next;
    logic [LOCAL_W-1:0] lz_reg, lz_next;
    logic [CMP_W-1:0]   cols_ext, rows_ext, last_col, last_row;
    logic               col_more, row_more;

    assign cols_ext = CMP_W'(cfg.columns);
    assign rows_ext = CMP_W'(cfg.rows);

    // clamp to [2, MAX_GRID_SIZE], then last index
    assign last_col = ((cols_ext < SIZE_MIN) ? SIZE_MIN :
                       (cols_ext > SIZE_MAX) ? SIZE_MAX : cols_ext) - CMP_W'(1);
    assign last_row = ((rows_ext < SIZE_MIN) ? SIZE_MIN :
                       (rows_ext > SIZE_MAX) ? SIZE_MAX : rows_ext) - CMP_W'(1);

    assign col_more  = CMP_W'(col_cnt_reg) < last_col;
    assign row_more  = CMP_W'(row_cnt_reg) < last_row;
    assign grid_last = !col_more && !row_more;
    assign local_x   = lx_reg;
    assign local_z   = lz_reg;

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        lx_next      = lx_reg;
        lz_next      = lz_reg;
        if (col_more) begin
            col_cnt_next = col_cnt_reg + CNT_W'(1);
            lx_next      = lx_reg + {1'b0, cfg.col_step};
        end else begin
            col_cnt_next = '0;
            lx_next      = MINUS_HALF;
            if (row_more) begin
                row_cnt_next = row_cnt_reg + CNT_W'(1);
                lz_next      = lz_reg + {1'b0, cfg.row_step};
            end else begin
                row_cnt_next = '0;
                lz_next      = MINUS_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            lx_reg      <= MINUS_HALF;
            lz_reg      <= MINUS_HALF;
        end else if (step) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            lx_reg      <= lx_next;
            lz_reg      <= lz_next;
        end
    end

endmodule

/* hw/rtl/hfb_bounds.sv */
// Running min/max of the world coordinates and the result output register.
// Depends on hfb_pkg; clears its extremes when a grid's bounds are emitted.
`timescale 1ns / 1ps

module hfb_bounds import hfb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    pt_valid,
    input  logic    pt_last,
    input  coord_t  wx,
    input  coord_t  wy,
    input  coord_t  wz,
    input  logic    out_ready,
    output logic    out_valid,
    output bounds_t out_bounds
);

    bounds_t run_reg, run_next;
    bounds_t out_reg;
    logic    out_valid_reg;

    always_comb begin
        run_next.min_x = (wx < run_reg.min_x) ? wx : run_reg.min_x;
        run_next.min_y = (wy < run_reg.min_y) ? wy : run_reg.min_y;
        run_next.min_z = (wz < run_reg.min_z) ? wz : run_reg.min_z;
        run_next.max_x = (wx > run_reg.max_x) ? wx : run_reg.max_x;
        run_next.max_y = (wy > run_reg.max_y) ? wy : run_reg.max_y;
        run_next.max_z = (wz > run_reg.max_z) ? wz : run_reg.max_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg.min_x <= COORD_MAX;
            run_reg.min_y <= COORD_MAX;
            run_reg.min_z <= COORD_MAX;
            run_reg.max_x <= COORD_MIN;
            run_reg.max_y <= COORD_MIN;
            run_reg.max_z <= COORD_MIN;
            out_valid_reg <= 1'b0;
        end else begin
            if (pt_valid && pt_last) begin
                run_reg.min_x <= COORD_MAX;
                run_reg.min_y <= COORD_MAX;
                run_reg.min_z <= COORD_MAX;
                run_reg.max_x <= COORD_MIN;
                run_reg.max_y <= COORD_MIN;
                run_reg.max_z <= COORD_MIN;
                out_valid_reg <= 1'b1;
            end else begin
                if (pt_valid) begin
                    run_reg <= run_next;
                end
                if (out_ready) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pt_valid && pt_last) begin
            out_reg <= run_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bounds = out_reg;

endmodule

/* hw/rtl/heightfield_transformed_bounds.sv */
// Output: m_tvalid rises after a grid's last word passes the input, transform and min/max stages.
// Throughput: one height word per cycle. s_tready drops only while a finished result is unread
//   and the next grid's last point is already waiting at the min/max stage.
// Pipeline: input register, world transform register (nine parallel multiplies), min/max stage.
// Reset: aresetn (synchronous, active low) restores config registers, valid flags, counters, positions and extremes.
// Depends on hfb_pkg, hfb_cfg, hfb_walk and hfb_bounds.
`timescale 1ns / 1ps

module heightfield_transformed_bounds import hfb_pkg::*; #(
    parameter int MAX_GRID_SIZE = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] height
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] bound_min_x, [63:32] bound_min_y, [95:64] bound_min_z,
    // [127:96] bound_max_x, [159:128] bound_max_y, [191:160] bound_max_z
    output logic [191:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    cfg_t    cfg;
    local_t  local_x, local_z;
    logic    grid_last;
    logic    accept, adv, stall;

    logic    a_valid_reg, a_last_reg;
    height_t a_height_reg;
    local_t  a_x_reg, a_z_reg;

    logic    b_valid_reg, b_last_reg;
    coord_t  b_wx_reg, b_wy_reg, b_wz_reg;

    bounds_t bounds;

    hfb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hfb_walk #(
        .MAX_GRID_SIZE (MAX_GRID_SIZE)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (accept),
        .local_x   (local_x),
        .local_z   (local_z),
        .grid_last (grid_last)
    );

    // hold the whole pipe only when a new result would overwrite an unread one
    assign stall    = b_valid_reg && b_last_reg && m_tvalid && !m_tready;
    assign adv      = !stall;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (accept) begin
                a_height_reg <= s_tdata;
                a_x_reg      <= local_x;
                a_z_reg      <= local_z;
                a_last_reg   <= grid_last;
            end
            b_last_reg <= a_last_reg;
            b_wx_reg   <= world(cfg.mrow_x, a_x_reg, a_height_reg, a_z_reg);
            b_wy_reg   <= world(cfg.mrow_y, a_x_reg, a_height_reg, a_z_reg);
            b_wz_reg   <= world(cfg.mrow_z, a_x_reg, a_height_reg, a_z_reg);
        end
    end

    hfb_bounds u_bounds (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pt_valid   (b_valid_reg && adv),
        .pt_last    (b_last_reg),
        .wx         (b_wx_reg),
        .wy         (b_wy_reg),
        .wz         (b_wz_reg),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_bounds (bounds)
    );

    assign m_tdata = bounds;

    // a grid's last point reaching the min/max stage produces a word next cycle
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_last_reg && adv |=> m_tvalid)
        else $error("last grid point did not produce a result word");

    // a taken word with no new last point leaves the output empty
    a_taken_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(b_valid_reg && b_last_reg) |=> !m_tvalid)
        else $error("result word repeated");

    // every grid has at least one point, so each minimum is at most its maximum
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bounds.min_x <= bounds.max_x) && (bounds.min_y <= bounds.max_y)
                     && (bounds.min_z <= bounds.max_z))
        else $error("bound minimum above maximum");

endmodule

/* sim/heightfield_transformed_bounds_tb.sv */
// Self-checking bench for heightfield_transformed_bounds: streams height grids, programs the
// matrix and grid registers over APB and compares every bounds word with a local predictor.
// Depends on hfb_pkg and the heightfield_transformed_bounds RTL.
`timescale 1ns / 1ps

module heightfield_transformed_bounds_tb;
    import hfb_pkg::*;

    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 240;
    localparam logic [2:0]  REG_NONE     = 3'd7;   // outside the register map

    // Running transform and min/max of the grid walk; holds the bounds words still due.
    class hfb_bounds_tracker;
        logic [63:0]        mrow [3];
        logic [10:0]        columns;
        logic [10:0]        rows;
        logic [15:0]        col_step;
        logic [15:0]        row_step;
        int unsigned        col_cnt;
        int unsigned        row_cnt;
        logic [LOCAL_W-1:0] pos_x;
        logic [LOCAL_W-1:0] pos_z;
        coord_t             lo [3];
        coord_t             hi [3];
        bounds_t            bounds_due [$];
        int                 errors;

        function new();
            mrow[0]  = 64'h0000_0000_0000_0100;
            mrow[1]  = 64'h0000_0000_0100_0000;
            mrow[2]  = 64'h0000_0100_0000_0000;
            columns  = 11'd2;
            rows     = 11'd2;
            col_step = 16'd32768;
            row_step = 16'd32768;
            errors   = 0;
            clear_walk();
        endfunction

        static function int unsigned grid_span(logic [10:0] n);
            if (n < 2) return 2;
            if (n > 1024) return 1024;
            return 32'(n);
        endfunction

        function void clear_walk();
            col_cnt = 0;
            row_cnt = 0;
            pos_x   = MINUS_HALF;
            pos_z   = MINUS_HALF;
            for (int k = 0; k < 3; k++) begin
                lo[k] = COORD_MAX;
                hi[k] = COORD_MIN;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_MATRIX_X: mrow[0]  = value;
                REG_MATRIX_Y: mrow[1]  = value;
                REG_MATRIX_Z: mrow[2]  = value;
                REG_COLUMNS:  columns  = value[10:0];
                REG_ROWS:     rows     = value[10:0];
                REG_COL_STEP: col_step = value[15:0];
                REG_ROW_STEP: row_step = value[15:0];
                default: ;
            endcase
        endfunction

        // x, z lanes give Q.23, the height lane Q16.16 (scaled up by 128), translation Q8.8
        function coord_t project(logic [63:0] row, logic [16:0] x, logic [15:0] h,
                                 logic [16:0] z);
            longint cx, cy, cz, ct, sx, sh, sz, acc, q;
            cx  = $signed(row[15:0]);
            cy  = $signed(row[31:16]);
            cz  = $signed(row[47:32]);
            ct  = $signed(row[63:48]);
            sx  = $signed(x);
            sh  = $signed(h);
            sz  = $signed(z);
            acc = cx * sx + cz * sz + cy * sh * 128 + ct * 32768;
            q   = (acc + 64) >>> 7;
            if (q > longint'(COORD_MAX)) return COORD_MAX;
            if (q < longint'(COORD_MIN)) return COORD_MIN;
            return q[31:0];
        endfunction

        function void note_height(logic [15:0] h);
            coord_t      w;
            int unsigned last_col;
            int unsigned last_row;
            bounds_t     b;
            for (int k = 0; k < 3; k++) begin
                w = project(mrow[k], pos_x, h, pos_z);
                if (w < lo[k]) lo[k] = w;
                if (w > hi[k]) hi[k] = w;
            end
            last_col = grid_span(columns) - 1;
            last_row = grid_span(rows) - 1;
            // a counter past a shrunken size behaves as if at the last index
            if (col_cnt < last_col) begin
                col_cnt++;
                pos_x = pos_x + col_step;
                return;
            end
            col_cnt = 0;
            pos_x   = MINUS_HALF;
            if (row_cnt < last_row) begin
                row_cnt++;
                pos_z = pos_z + row_step;
                return;
            end
            b.min_x = lo[0];
            b.min_y = lo[1];
            b.min_z = lo[2];
            b.max_x = hi[0];
            b.max_y = hi[1];
            b.max_z = hi[2];
            bounds_due = {bounds_due, b};
            clear_walk();
        endfunction

        function void check_bounds(logic [191:0] got);
            logic [191:0] want;
            string        field [6];
            field = '{"bound_min_x", "bound_min_y", "bound_min_z",
                      "bound_max_x", "bound_max_y", "bound_max_z"};
            if (bounds_due.size() == 0) begin
                errors++;
                $display("%0t: bounds word with none due: expected nothing, got %h", $time, got);
                return;
            end
            want = bounds_due.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (want[32*f +: 32] !== got[32*f +: 32]) begin
                    errors++;
                    $display("%0t: %s mismatch: expected %h, got %h", $time, field[f],
                             want[32*f +: 32], got[32*f +: 32]);
                end
            end
        endfunction

        function void flush_leftovers();
            while (bounds_due.size() != 0) begin
                errors++;
                $display("%0t: bounds word never arrived: expected %h, got nothing",
                         $time, bounds_due.pop_front());
            end
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;        // [15:0] height
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] min_x, [63:32] min_y, [95:64] min_z, [127:96] max_x, [159:128] max_y,
    // [191:160] max_z
    logic [191:0] m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [5:0]   paddr    = '0;
    logic [63:0]  pwdata   = '0;
    logic [63:0]  prdata;
    logic         pready;

    hfb_bounds_tracker tracker = new();

    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_cnt   = 0;
    bit          hold_start = 1'b0;
    int unsigned cycles     = 0;

    heightfield_transformed_bounds #(.MAX_GRID_SIZE(1024)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("heightfield_transformed_bounds_tb: FAIL");
            $finish;
        end
    end

    // Result side: check the word taken at this edge, then pick next cycle's ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_bounds(m_tdata);
        end
        if (hold_start) begin
            hold_start = 1'b0;
            hold_cnt   = HOLD_CYCLES;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic set_matrix(input logic [63:0] rx, input logic [63:0] ry,
                              input logic [63:0] rz);
        write_reg(REG_MATRIX_X, rx);
        write_reg(REG_MATRIX_Y, ry);
        write_reg(REG_MATRIX_Z, rz);
    endtask

    task automatic set_grid(input logic [10:0] cols, input logic [10:0] rows,
                            input logic [15:0] cstep, input logic [15:0] rstep);
        write_reg(REG_COLUMNS, 64'(cols));
        write_reg(REG_ROWS, 64'(rows));
        write_reg(REG_COL_STEP, 64'(cstep));
        write_reg(REG_ROW_STEP, 64'(rstep));
    endtask

    // valid stays up from one word to the next unless a gap is drawn
    task automatic send_height(input logic [15:0] h);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        do @(posedge aclk); while (!s_tready);
        tracker.note_height(h);
    endtask

    // wait for every bounds word due, then let words of an unfinished grid clear the pipe
    task automatic drain();
        while (tracker.bounds_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] step_for(input int unsigned span);
        return 16'(32768 / (span - 1));
    endfunction

    function automatic logic [15:0] rand_height();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [63:0] random_row();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int unsigned span_c;
        int unsigned span_r;
        int unsigned n;
        int unsigned sent;
        logic [10:0] cols;
        logic [10:0] rows;
        logic [15:0] cstep;
        logic [15:0] rstep;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setup: unit matrix on a 2x2 grid, extreme heights
        send_height(16'h7FFF);
        send_height(16'h8000);
        send_height(16'h0000);
        send_height(16'hFFFF);
        s_tvalid <= 1'b0;
        drain();

        // extreme coefficients, sizes below the minimum, zero and all-ones steps
        set_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                   64'h7FFF_8000_0001_FFFF);
        set_grid(11'd0, 11'd1, 16'd0, 16'hFFFF);
        write_reg(REG_NONE, '1);
        send_height(16'h7FFF);
        send_height(16'h8000);
        send_height(16'h8000);
        send_height(16'h7FFF);
        s_tvalid <= 1'b0;
        drain();

        // oversized width, then shrink it while the row is part way walked
        set_grid(11'd2047, 11'd2, 16'hFFFF, 16'd32768);
        repeat (5) send_height(rand_height());
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_COLUMNS, 64'd3);
        repeat (4) send_height(rand_height());
        s_tvalid <= 1'b0;
        drain();

        // long result hold-off with small grids so the block backs up into its input
        set_grid(11'd2, 11'd2, 16'd32768, 16'd32768);
        hold_start = 1'b1;
        repeat (40) send_height(rand_height());
        s_tvalid <= 1'b0;

        for (int p = 0; p < 4; p++) begin
            send_idle  = (p == 1) ? 50 : (p == 3) ? 12 : 0;
            recv_stall = (p == 2) ? 50 : (p == 3) ? 12 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                drain();
                cols   = ($urandom_range(4) == 0) ? 11'($urandom_range(7, 40))
                                                  : 11'($urandom_range(0, 6));
                rows   = 11'($urandom_range(0, 5));
                span_c = hfb_bounds_tracker::grid_span(cols);
                span_r = hfb_bounds_tracker::grid_span(rows);
                cstep  = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : step_for(span_c);
                rstep  = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : step_for(span_r);
                set_matrix(random_row(), random_row(), random_row());
                set_grid(cols, rows, cstep, rstep);
                n = $urandom_range(1, 3) * span_c * span_r;
                // sometimes leave a grid unfinished so the next setting lands mid-grid
                if ($urandom_range(5) == 0) n += $urandom_range(1, span_c * span_r - 1);
                repeat (n) send_height(rand_height());
                s_tvalid <= 1'b0;
                sent += n;
            end
        end

        drain();
        tracker.flush_leftovers();
        if (tracker.errors == 0) begin
            $display("heightfield_transformed_bounds_tb: PASS");
        end else begin
            $display("heightfield_transformed_bounds_tb: FAIL");
        end
        $finish;
    end

endmodule
